// File: src/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

	localparam int BYTE_W      = 8;
	localparam int STORE_BYTES = 16;   // pattern bytes held by the register file
	localparam int POS_W       = 4;    // index of a pattern position
	localparam int LEN_W       = 5;    // width of the pattern length register
	localparam int REG_W       = 64;   // widest configuration register
	localparam int ADDR_W      = 64;
	localparam int OFF_OUT_W   = 32;   // match offset as reported
	localparam int IDX_W       = 3;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [IDX_W-1:0] REG_WILDCARD     = 3'd2;
	localparam logic [IDX_W-1:0] REG_LENGTH       = 3'd3;
	localparam logic [IDX_W-1:0] REG_BASE         = 3'd4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [STORE_BYTES-1:0][BYTE_W-1:0] window_t;

	// pattern re-ordered so that entry j lines up with the byte j beats back
	typedef struct packed {
		window_t                  apat;
		logic [STORE_BYTES-1:0]   dc;       // position matches anything
		logic [POS_W-1:0]         len_m1;
		logic [ADDR_W-1:0]        base_adj; // base address less (length - 1)
	} cfg_t;

	typedef struct packed {
		logic                 found;
		logic [ADDR_W-1:0]    address;
		logic [OFF_OUT_W-1:0] offset;
	} res_t;

endpackage

`default_nettype wire

// File: src/wbps_cfg.sv
// ----------------------------------------------------------------------------
// wbps_cfg
// Configuration registers and the length-aligned view of the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cfg #(
	parameter int MAX_PATTERN = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [wbps_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [wbps_pkg::REG_W-1:0]  cfg_data,
	output wbps_pkg::cfg_t                   cfg
);
	import wbps_pkg::*;

	localparam int LIM = (MAX_PATTERN < STORE_BYTES) ? MAX_PATTERN : STORE_BYTES;

	logic [REG_W-1:0]       pat_lo_q;
	logic [REG_W-1:0]       pat_hi_q;
	logic [STORE_BYTES-1:0] mask_q;
	logic [POS_W-1:0]       len_m1_q;
	logic [ADDR_W-1:0]      base_q;
	logic [LEN_W-1:0]       len_wr;
	logic [LEN_W-1:0]       len_clip;
	logic [2*REG_W-1:0]     pat_all;

	// zero counts as one, anything above the limit as the limit
	always_comb begin
		len_wr = cfg_data[LEN_W-1:0];
		if (len_wr == '0) begin
			len_clip = LEN_W'(1);
		end else if (len_wr > LEN_W'(LIM)) begin
			len_clip = LEN_W'(LIM);
		end else begin
			len_clip = len_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			mask_q   <= '0;
			len_m1_q <= '0;
			base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LOW:  pat_lo_q <= cfg_data;
				REG_PATTERN_HIGH: pat_hi_q <= cfg_data;
				REG_WILDCARD:     mask_q   <= cfg_data[STORE_BYTES-1:0];
				REG_LENGTH:       len_m1_q <= POS_W'(len_clip - LEN_W'(1));
				REG_BASE:         base_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign pat_all = {pat_hi_q, pat_lo_q};

	// position j of the window is pattern byte (length - 1 - j)
	always_comb begin
		logic [POS_W-1:0] k;
		for (int j = 0; j < STORE_BYTES; j++) begin
			k = len_m1_q - POS_W'(j);
			cfg.apat[j] = pat_all[k*BYTE_W +: BYTE_W];
			cfg.dc[j]   = (POS_W'(j) > len_m1_q) | mask_q[k];
		end
		cfg.len_m1   = len_m1_q;
		cfg.base_adj = base_q - ADDR_W'(len_m1_q);
	end

endmodule

`default_nettype wire

// File: src/wbps_match.sv
// ----------------------------------------------------------------------------
// wbps_match
// Masked parallel compare of the byte window against the aligned pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_match (
	input  wire wbps_pkg::window_t              win,
	input  wire wbps_pkg::window_t              apat,
	input  wire logic [wbps_pkg::STORE_BYTES-1:0] dc,
	output logic                                 hit
);
	import wbps_pkg::*;

	logic [STORE_BYTES-1:0] pos_ok;

	always_comb begin
		for (int j = 0; j < STORE_BYTES; j++) begin
			pos_ok[j] = dc[j] | (win[j] == apat[j]);
		end
	end

	assign hit = &pos_ok;

endmodule

`default_nettype wire

// File: src/wbps_scan.sv
// ----------------------------------------------------------------------------
// wbps_scan
// Byte window, stream offset counter and first-match latch for one region.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_scan #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     step,
	input  wire logic [wbps_pkg::BYTE_W-1:0] cur,
	input  wire logic                     last,
	input  wire wbps_pkg::cfg_t           cfg,
	output wbps_pkg::res_t                res
);
	import wbps_pkg::*;

	localparam int LIM = (MAX_PATTERN < STORE_BYTES) ? MAX_PATTERN : STORE_BYTES;
	localparam int RD  = (LIM > 1) ? LIM - 1 : 1;

	byte_t                  recent_q [RD];
	logic [OFFSET_BITS-1:0] seen_q;
	logic                   latched_q;
	logic [OFFSET_BITS-1:0] first_off_q;
	logic [ADDR_W-1:0]      first_addr_q;

	window_t                win;
	logic                   win_hit;
	logic                   hit;
	logic                   latched_n;
	logic [OFFSET_BITS-1:0] cand_off;
	logic [ADDR_W-1:0]      cand_addr;
	logic [OFFSET_BITS-1:0] off_n;
	logic [ADDR_W-1:0]      addr_n;

	// window entry j is the byte j beats back, entry 0 the current one
	assign win[0] = cur;
	for (genvar j = 1; j < STORE_BYTES; j++) begin : g_win
		if (j < LIM) begin : g_used
			assign win[j] = recent_q[j-1];
		end else begin : g_unused
			assign win[j] = '0;
		end
	end

	wbps_match u_match (
		.win  (win),
		.apat (cfg.apat),
		.dc   (cfg.dc),
		.hit  (win_hit)
	);

	always_comb begin
		hit       = win_hit && !latched_q && (seen_q >= OFFSET_BITS'(cfg.len_m1));
		cand_off  = seen_q - OFFSET_BITS'(cfg.len_m1);
		cand_addr = cfg.base_adj + ADDR_W'(seen_q);
		latched_n = latched_q | hit;
		off_n     = hit ? cand_off  : first_off_q;
		addr_n    = hit ? cand_addr : first_addr_q;

		res.found   = latched_n;
		res.offset  = latched_n ? OFF_OUT_W'(off_n) : '0;
		res.address = latched_n ? addr_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RD; i++) begin
				recent_q[i] <= '0;
			end
			seen_q    <= '0;
			latched_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				for (int i = 0; i < RD; i++) begin
					recent_q[i] <= '0;
				end
				seen_q    <= '0;
				latched_q <= 1'b0;
			end else begin
				recent_q[0] <= cur;
				for (int i = 1; i < RD; i++) begin
					recent_q[i] <= recent_q[i-1];
				end
				// offset saturates at all ones
				if (seen_q != '1) begin
					seen_q <= seen_q + OFFSET_BITS'(1);
				end
				latched_q <= latched_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit) begin
			first_off_q  <= cand_off;
			first_addr_q <= cand_addr;
		end
	end

endmodule

`default_nettype wire

// File: src/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Finds the first occurrence of a wildcard byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per beat on the slave side; a beat with tlast closes the
// region and produces one result beat: found in tuser, the start offset of
// the first match and base address plus that offset in tdata (both zero when
// nothing matched). Throughput is one byte per clock while the input does
// not stall; a result beat is valid from the clock edge that moves its last
// byte out of the input register. Each byte goes through an input register
// and then a single masked compare of a 16-byte window against the pattern,
// so a match is tested on every byte. The input stalls only when a last byte
// sits in the input register while the previous result has not been taken.
// The stream offset saturates at 2^OFFSET_BITS - 1.
`default_nettype none

module wildcard_byte_pattern_scanner #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	// byte stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  wire logic         s_axis_tlast,   // last_byte
	// result
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [95:0]       m_axis_tdata,   // [31:0] match_offset, [95:32] match_address
	output logic              m_axis_tuser    // found
);
	import wbps_pkg::*;

	cfg_t  cfg;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;
	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;
	logic  step;

	wbps_cfg #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a plain byte always moves on; a last byte needs a free result slot
	assign step          = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata[BYTE_W-1:0];
			last_s1 <= s_axis_tlast;
		end
	end

	wbps_scan #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cur    (byte_s1),
		.last   (last_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.found;
	assign m_axis_tdata  = {res_q.address, res_q.offset};

	// a result beat only follows a last byte leaving the input register
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(step && last_s1))
		else $error("result beat without a closing byte");

	// no match means zero offset and address
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("non-zero data on a not-found result");

	// back-pressure only from a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a pending result");

endmodule

`default_nettype wire

// File: tb/sv/wildcard_byte_pattern_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_tb
// Self-checking bench for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
// Byte beats are pushed into the slave side and run through a local scan
// model as they are accepted. Each last byte queues the expected region
// result, and the master side is compared field by field against the head
// of that queue. Directed regions cover the length clamps, full wildcards,
// address wrap, short regions and ignored register writes. Random phases
// then reconfigure the block and scan regions seeded with the pattern.
// Both sides idle at random, the receiver is held off for a long stretch,
// and the sender pauses until all results are back.
`default_nettype none

module wildcard_byte_pattern_scanner_tb;
	import wbps_pkg::*;

	typedef struct {
		logic                 found;
		logic [OFF_OUT_W-1:0] offset;
		logic [ADDR_W-1:0]    address;
	} scan_res_t;

	localparam int HOLD_CYCLES = 200;

	logic             clk            = 1'b0;
	logic             arst_n         = 1'b0;
	logic             cfg_we         = 1'b0;
	logic [IDX_W-1:0] cfg_index      = '0;
	logic [REG_W-1:0] cfg_data       = '0;
	logic             s_axis_tvalid  = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata   = '0;   // [7:0] data_byte
	logic             s_axis_tlast   = 1'b0; // last_byte
	logic             m_axis_tvalid;
	logic             m_axis_tready  = 1'b0;
	logic [95:0]      m_axis_tdata;          // [31:0] match_offset, [95:32] match_address
	logic             m_axis_tuser;          // found

	wildcard_byte_pattern_scanner u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// scan model: registers
	logic [63:0] pat_lo    = '0;
	logic [63:0] pat_hi    = '0;
	logic [15:0] wild      = '0;
	logic [4:0]  len_reg   = 5'd1;
	logic [63:0] base_addr = '0;

	// scan model: region state
	logic [7:0]  hist [0:14];
	logic [31:0] seen_cnt    = '0;
	bit          hit_latched = 1'b0;
	logic [31:0] hit_start   = '0;

	scan_res_t pending_res_q [$];
	int        err_cnt   = 0;
	bit        tx_idle   = 1'b1;
	bit        rx_idle   = 1'b1;
	int        hold_seq  = 0;
	int        hold_seen = 0;
	int        hold_cnt  = 0;
	int        rx_wait   = 0;

	initial begin
		for (int i = 0; i < 15; i++)
			hist[i] = '0;
	end

	function automatic int unsigned eff_len();
		int unsigned l;
		l = len_reg;
		if (l == 0)
			l = 1;
		if (l > STORE_BYTES)
			l = STORE_BYTES;
		return l;
	endfunction

	function automatic logic [7:0] pat_byte(int k);
		if (k < 8)
			return pat_lo[8*k +: 8];
		return pat_hi[8*(k-8) +: 8];
	endfunction

	task automatic scan_byte(input logic [7:0] d, input bit l);
		int unsigned n;
		bit          hit;
		logic [7:0]  b;
		scan_res_t   r;
		n = eff_len();
		if (!hit_latched && seen_cnt >= n - 1) begin
			hit = 1'b1;
			for (int k = 0; k < n; k++) begin
				if (!wild[k]) begin
					b = (n - 1 - k == 0) ? d : hist[n - 2 - k];
					if (b != pat_byte(k))
						hit = 1'b0;
				end
			end
			if (hit) begin
				hit_latched = 1'b1;
				hit_start   = seen_cnt - (n - 1);
			end
		end
		for (int i = 14; i > 0; i--)
			hist[i] = hist[i-1];
		hist[0] = d;
		if (seen_cnt != '1)
			seen_cnt++;
		if (l) begin
			r.found   = hit_latched;
			r.offset  = hit_latched ? hit_start : '0;
			r.address = hit_latched ? base_addr + {32'd0, hit_start} : '0;
			pending_res_q = {pending_res_q, r};
			for (int i = 0; i < 15; i++)
				hist[i] = '0;
			seen_cnt    = '0;
			hit_latched = 1'b0;
			hit_start   = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	// result side: check accepted beats, then decide ready for the next edge
	always @(posedge clk) begin
		scan_res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_res_q.size() == 0) begin
				report_mismatch("unexpected beat", m_axis_tdata[95:32], '0);
			end else begin
				e = pending_res_q.pop_front();
				if (m_axis_tuser !== e.found)
					report_mismatch("found", 64'(m_axis_tuser), 64'(e.found));
				if (m_axis_tdata[31:0] !== e.offset)
					report_mismatch("match_offset", 64'(m_axis_tdata[31:0]), 64'(e.offset));
				if (m_axis_tdata[95:32] !== e.address)
					report_mismatch("match_address", m_axis_tdata[95:32], e.address);
			end
			rx_wait = rx_idle ? $urandom_range(0, 13) : 0;
		end
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_cnt  = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic push_byte(input logic [7:0] d, input bit l);
		int gap;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tlast  <= l;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		scan_byte(d, l);
	endtask

	// stop offering, wait for every result, then let the pipe empty
	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_res_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PATTERN_LOW:  pat_lo    = v;
			REG_PATTERN_HIGH: pat_hi    = v;
			REG_WILDCARD:     wild      = v[15:0];
			REG_LENGTH:       len_reg   = v[4:0];
			REG_BASE:         base_addr = v;
			default: ;
		endcase
	endtask

	task automatic send_region(input int n, input bit plant, input bit broken);
		logic [7:0] region_bytes [$];
		int         l;
		int         pos;
		bit         from_pat;
		l        = eff_len();
		from_pat = $urandom_range(0, 1);
		for (int i = 0; i < n; i++)
			region_bytes = {region_bytes,
					(from_pat ? pat_byte($urandom_range(0, l - 1)) : 8'($urandom))};
		if (plant && n >= l) begin
			pos = $urandom_range(0, n - l);
			for (int k = 0; k < l; k++)
				if (!wild[k])
					region_bytes[pos + k] = pat_byte(k);
			if (broken)
				region_bytes[pos + $urandom_range(0, l - 1)] ^= 8'h01 << $urandom_range(0, 7);
		end
		for (int i = 0; i < n; i++)
			push_byte(region_bytes[i], i == n - 1);
	endtask

	task automatic random_config();
		logic [63:0] v;
		int          sel;
		cfg_write(REG_PATTERN_LOW, {$urandom, $urandom});
		cfg_write(REG_PATTERN_HIGH, {$urandom, $urandom});
		v   = {$urandom, $urandom};
		sel = $urandom_range(0, 9);
		if (sel < 3)
			v[15:0] = '0;
		else if (sel == 3)
			v[15:0] = '1;
		else
			v[15:0] = 16'($urandom & $urandom);
		cfg_write(REG_WILDCARD, v);
		v   = {$urandom, $urandom};
		sel = $urandom_range(0, 9);
		case (sel)
			0:       v[4:0] = 5'd1;
			1:       v[4:0] = 5'd16;
			2:       v[4:0] = 5'($urandom_range(0, 31));
			default: v[4:0] = 5'($urandom_range(1, 6));
		endcase
		cfg_write(REG_LENGTH, v);
		sel = $urandom_range(0, 9);
		cfg_write(REG_BASE, sel == 0 ? 64'd0 : sel == 1 ? '1 : {$urandom, $urandom});
	endtask

	task automatic test_reset_defaults();
		// pattern byte 00, length 1
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		settle_idle();
	endtask

	task automatic test_length_zero_wrap();
		// length 0 acts as 1; match on the last byte, address wraps
		cfg_write(REG_PATTERN_LOW, 64'h0000_0000_0000_00AB);
		cfg_write(REG_LENGTH, 64'd0);
		cfg_write(REG_BASE, '1);
		push_byte(8'h12, 1'b0);
		push_byte(8'hAB, 1'b1);
		settle_idle();
	endtask

	task automatic test_length_clamp_full_wild();
		// 31 is clamped to 16; every position a wildcard
		cfg_write(REG_LENGTH, 64'd31);
		cfg_write(REG_WILDCARD, 64'hFFFF);
		cfg_write(REG_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
		for (int i = 0; i < 16; i++)
			push_byte(i[0] ? 8'hFF : 8'h00, i == 15);
		settle_idle();
	endtask

	task automatic test_short_region_and_bad_index();
		cfg_write(REG_PATTERN_LOW, 64'h5A5A_5A5A_5AC0_B0A0);
		cfg_write(REG_WILDCARD, 64'd0);
		cfg_write(REG_LENGTH, 64'd3);
		cfg_write(REG_BASE, 64'h0123_4567_89AB_CDEF);
		// region ends before the pattern fits
		push_byte(8'hA0, 1'b0);
		push_byte(8'hB0, 1'b1);
		settle_idle();
		for (int i = int'(REG_BASE) + 1; i < (1 << IDX_W); i++)
			cfg_write(IDX_W'(i), {$urandom, $urandom});
		push_byte(8'hA0, 1'b0);
		push_byte(8'hB0, 1'b0);
		push_byte(8'hC0, 1'b1);
		settle_idle();
	endtask

	task automatic test_random_phases();
		int items;
		int n;
		int kind;
		items = 0;
		while (items < 1800) begin
			settle_idle();
			random_config();
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			for (int r = $urandom_range(3, 8); r > 0; r--) begin
				n    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
						: $urandom_range(1, 24);
				kind = $urandom_range(0, 9);
				send_region(n, kind < 7, kind == 6);
				items += n;
			end
		end
		settle_idle();
	endtask

	task automatic test_backpressure();
		// short regions against a stalled receiver so the input backs up
		cfg_write(REG_LENGTH, 64'd2);
		cfg_write(REG_WILDCARD, 64'd0);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_seq++;
		for (int r = 0; r < 40; r++)
			send_region($urandom_range(1, 3), 1'b1, 1'b0);
		settle_idle();
	endtask

	task automatic test_sender_pause();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int r = 0; r < 4; r++)
			send_region($urandom_range(1, 8), 1'b1, 1'b0);
		settle_idle();
		for (int r = 0; r < 4; r++)
			send_region($urandom_range(1, 8), 1'b1, 1'b0);
		settle_idle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_length_zero_wrap();
		test_length_clamp_full_wild();
		test_short_region_and_bad_index();
		test_random_phases();
		test_backpressure();
		test_sender_pause();
		settle_idle();
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
